// File: hw/rtl/cma_pkg.sv
// ----------------------------------------------------------------------------
// cma_pkg: shared types and constants of the confusion matrix accumulator
// Item layouts, opcodes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package cma_pkg;

    localparam int CLASS_COUNT_DEF = 16;
    localparam int COUNT_BITS_DEF  = 32;

    localparam int OPCODE_W    = 2;
    localparam int CLASS_W     = 4;
    localparam int COUNT_OUT_W = 32;
    localparam int FRAC_W      = 16;

    localparam logic [OPCODE_W-1:0] OP_RECORD = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_READ   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_NOP    = 2'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [CLASS_W-1:0]  true_class;
        logic [CLASS_W-1:0]  predicted_class;
    } t_in_item;

    typedef struct packed {
        logic [CLASS_W-1:0]     column;
        logic [COUNT_OUT_W-1:0] cell_count;
        logic [COUNT_OUT_W-1:0] row_total;
        logic [FRAC_W-1:0]      fraction;
        logic                   last;
    } t_out_item;

endpackage

// File: hw/rtl/cma_stream_if.sv
// ----------------------------------------------------------------------------
// cma_stream_if: valid/ready stream channel
// One transfer at each rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface cma_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/confusion_matrix_accumulator.sv
// ----------------------------------------------------------------------------
// confusion_matrix_accumulator: class-by-class count matrix with row read-out
//
//   channel | dir | payload     | role
//   i_in    | in  | t_in_item   | record pair / read row / clear
//   o_out   | out | t_out_item  | one result per column of a read row
//
// Records: one per cycle while no read or clear runs; read-modify-write over the
// cell and row-total RAMs (registered read data), back-to-back hits on one entry
// forwarded. Reads: per column a RAM read, a load and a 16-step ratio unit run,
// skipped in the zero and full-scale cases; a stalled o_out holds the read.
// Clear and reset: a clearing pass over all CLASS_COUNT*CLASS_COUNT cells with
// i_in.ready low. A waiting result in o_out does not stall record transfers.
// ----------------------------------------------------------------------------
module confusion_matrix_accumulator #(
    parameter int CLASS_COUNT = cma_pkg::CLASS_COUNT_DEF,
    parameter int COUNT_BITS  = cma_pkg::COUNT_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cma_stream_if.sink   i_in,
    cma_stream_if.source o_out
);
    import cma_pkg::*;

    localparam int IDX_W = $clog2(CLASS_COUNT);
    localparam int CELLS = CLASS_COUNT * CLASS_COUNT;
    localparam int AW    = $clog2(CELLS);
    localparam int LOW_W = (COUNT_BITS < COUNT_OUT_W) ? COUNT_BITS : COUNT_OUT_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RADDR = 3'd2;
    localparam logic [2:0] ST_LOAD  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;

    localparam logic [IDX_W-1:0] COL_LAST  = IDX_W'(CLASS_COUNT - 1);
    localparam logic [AW-1:0]    CELL_LAST = AW'(CELLS - 1);

    logic [2:0]            r_state, n_state;
    logic [AW-1:0]         r_clr_cnt, n_clr_cnt;
    logic [IDX_W-1:0]      r_rd_row, n_rd_row;
    logic [IDX_W-1:0]      r_rd_col, n_rd_col;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic [COUNT_BITS-1:0] r_tot, n_tot;

    // record pipeline and write-back forwarding
    logic                  r_s1_valid, n_s1_valid;
    logic [AW-1:0]         r_s1_caddr, n_s1_caddr;
    logic [IDX_W-1:0]      r_s1_row, n_s1_row;
    logic                  r_fw_valid;
    logic [AW-1:0]         r_fw_caddr;
    logic [IDX_W-1:0]      r_fw_row;
    logic [COUNT_BITS-1:0] r_fw_cdata;
    logic [COUNT_BITS-1:0] r_fw_tdata;

    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;

    logic                  w_in_xfer;
    logic                  w_in_ok;
    logic [IDX_W-1:0]      w_in_row, w_in_col;
    logic [AW-1:0]         w_in_caddr;
    logic [AW-1:0]         w_rd_caddr;
    logic                  w_out_free;

    logic                  w_cell_we, w_row_we;
    logic [AW-1:0]         w_cell_waddr, w_cell_raddr;
    logic [IDX_W-1:0]      w_row_waddr, w_row_raddr;
    logic [COUNT_BITS-1:0] w_cell_wdata, w_row_wdata;
    logic [COUNT_BITS-1:0] w_cell_rdata, w_row_rdata;
    logic [COUNT_BITS-1:0] w_cell_old, w_row_old;
    logic [COUNT_BITS-1:0] w_cell_new, w_row_new;

    logic                  w_div_start;
    logic                  w_div_busy;
    logic [FRAC_W-1:0]     w_div_quot;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    assign w_in_ok = (32'(i_in.data.true_class) < 32'(CLASS_COUNT))
                  && (32'(i_in.data.predicted_class) < 32'(CLASS_COUNT));
    assign w_in_row   = IDX_W'(i_in.data.true_class);
    assign w_in_col   = IDX_W'(i_in.data.predicted_class);
    assign w_in_caddr = AW'(32'(w_in_row) * 32'(CLASS_COUNT) + 32'(w_in_col));
    assign w_rd_caddr = AW'(32'(r_rd_row) * 32'(CLASS_COUNT) + 32'(r_rd_col));

    // saturating read-modify-write with one-back forwarding
    assign w_cell_old = (r_fw_valid && r_fw_caddr == r_s1_caddr) ? r_fw_cdata : w_cell_rdata;
    assign w_row_old  = (r_fw_valid && r_fw_row == r_s1_row) ? r_fw_tdata : w_row_rdata;
    assign w_cell_new = (w_cell_old == '1) ? w_cell_old : w_cell_old + 1'b1;
    assign w_row_new  = (w_row_old == '1) ? w_row_old : w_row_old + 1'b1;

    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_cell_we    = 1'b1;
            w_cell_waddr = r_clr_cnt;
            w_cell_wdata = '0;
            w_row_we     = (32'(r_clr_cnt) < 32'(CLASS_COUNT));
            w_row_waddr  = r_clr_cnt[IDX_W-1:0];
            w_row_wdata  = '0;
        end else begin
            w_cell_we    = r_s1_valid;
            w_cell_waddr = r_s1_caddr;
            w_cell_wdata = w_cell_new;
            w_row_we     = r_s1_valid;
            w_row_waddr  = r_s1_row;
            w_row_wdata  = w_row_new;
        end
        if (r_state == ST_IDLE) begin
            w_cell_raddr = w_in_caddr;
            w_row_raddr  = w_in_row;
        end else begin
            w_cell_raddr = w_rd_caddr;
            w_row_raddr  = r_rd_row;
        end
    end

    cma_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (w_cell_we),
        .i_waddr (w_cell_waddr),
        .i_wdata (w_cell_wdata),
        .i_raddr (w_cell_raddr),
        .o_rdata (w_cell_rdata)
    );

    cma_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (CLASS_COUNT)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_row_we),
        .i_waddr (w_row_waddr),
        .i_wdata (w_row_wdata),
        .i_raddr (w_row_raddr),
        .o_rdata (w_row_rdata)
    );

    assign w_div_start = (r_state == ST_LOAD);

    cma_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_cell_rdata),
        .i_den   (w_row_rdata),
        .o_busy  (w_div_busy),
        .o_quot  (w_div_quot)
    );

    always_comb begin
        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_rd_row    = r_rd_row;
        n_rd_col    = r_rd_col;
        n_cnt       = r_cnt;
        n_tot       = r_tot;
        n_s1_valid  = 1'b0;
        n_s1_caddr  = w_in_caddr;
        n_s1_row    = w_in_row;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        case (r_state)
            ST_CLEAR: begin
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (r_clr_cnt == CELL_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_in_xfer) begin
                    case (i_in.data.opcode)
                        OP_RECORD: n_s1_valid = w_in_ok;
                        OP_READ: begin
                            if (32'(i_in.data.true_class) < 32'(CLASS_COUNT)) begin
                                n_rd_row = w_in_row;
                                n_rd_col = '0;
                                n_state  = ST_RADDR;
                            end
                        end
                        OP_CLEAR: begin
                            n_clr_cnt = '0;
                            n_state   = ST_CLEAR;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_RADDR: n_state = ST_LOAD;
            ST_LOAD: begin
                n_cnt   = w_cell_rdata;
                n_tot   = w_row_rdata;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (!w_div_busy && w_out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.column        = CLASS_W'(r_rd_col);
                    n_out.cell_count    = '0;
                    n_out.row_total     = '0;
                    n_out.cell_count[LOW_W-1:0] = r_cnt[LOW_W-1:0];
                    n_out.row_total[LOW_W-1:0]  = r_tot[LOW_W-1:0];
                    n_out.fraction      = w_div_quot;
                    n_out.last          = (r_rd_col == COL_LAST);
                    n_rd_col            = r_rd_col + 1'b1;
                    n_state             = (r_rd_col == COL_LAST) ? ST_IDLE : ST_RADDR;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_s1_valid  <= 1'b0;
            r_fw_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_s1_valid  <= n_s1_valid;
            r_fw_valid  <= r_s1_valid;
            r_out_valid <= n_out_valid;
        end
        r_rd_row   <= n_rd_row;
        r_rd_col   <= n_rd_col;
        r_cnt      <= n_cnt;
        r_tot      <= n_tot;
        r_s1_caddr <= n_s1_caddr;
        r_s1_row   <= n_s1_row;
        r_fw_caddr <= r_s1_caddr;
        r_fw_row   <= r_s1_row;
        r_fw_cdata <= w_cell_new;
        r_fw_tdata <= w_row_new;
        r_out      <= n_out;
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
endmodule

// File: hw/rtl/cma_ram.sv
// ----------------------------------------------------------------------------
// cma_ram: generic synchronous RAM
// One write port, one read port, read data registered (read-before-write).
// ----------------------------------------------------------------------------
module cma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/cma_div.sv
// ----------------------------------------------------------------------------
// cma_div: Q0.16 ratio unit
// floor(num * 2^16 / den), one quotient bit per cycle by restoring division;
// zero total gives 0, count at or above total gives the full-scale value.
// ----------------------------------------------------------------------------
module cma_div #(
    parameter int COUNT_BITS = cma_pkg::COUNT_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [COUNT_BITS-1:0]     i_num,
    input  logic [COUNT_BITS-1:0]     i_den,
    output logic                      o_busy,
    output logic [cma_pkg::FRAC_W-1:0] o_quot
);
    import cma_pkg::*;

    localparam int STEP_W = $clog2(FRAC_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(FRAC_W - 1);

    logic                  r_busy, n_busy;
    logic [STEP_W-1:0]     r_step, n_step;
    logic [COUNT_BITS-1:0] r_rem, n_rem;
    logic [COUNT_BITS-1:0] r_den, n_den;
    logic [FRAC_W-1:0]     r_q, n_q;
    logic [COUNT_BITS:0]   w_rem2;
    logic [COUNT_BITS:0]   w_diff;

    assign w_rem2 = {r_rem, 1'b0};
    assign w_diff = w_rem2 - {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        n_rem  = r_rem;
        n_den  = r_den;
        n_q    = r_q;
        if (i_start) begin
            n_den  = i_den;
            n_rem  = i_num;
            n_step = '0;
            if (i_den == '0) begin
                n_q    = '0;
                n_busy = 1'b0;
            end else if (i_num >= i_den) begin
                n_q    = '1;
                n_busy = 1'b0;
            end else begin
                n_q    = '0;
                n_busy = 1'b1;
            end
        end else if (r_busy) begin
            if (w_rem2 >= {1'b0, r_den}) begin
                n_rem = w_diff[COUNT_BITS-1:0];
                n_q   = {r_q[FRAC_W-2:0], 1'b1};
            end else begin
                n_rem = w_rem2[COUNT_BITS-1:0];
                n_q   = {r_q[FRAC_W-2:0], 1'b0};
            end
            n_step = r_step + 1'b1;
            if (r_step == STEP_LAST) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_step <= n_step;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_q    <= n_q;
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;
endmodule

// File: hw/rtl/cma_chk.sv
// ----------------------------------------------------------------------------
// cma_chk: port-level checks of the confusion matrix accumulator
// Watches the input and output channels; bound to the top level.
// ----------------------------------------------------------------------------
module cma_chk #(
    parameter int CLASS_COUNT = cma_pkg::CLASS_COUNT_DEF,
    parameter int COUNT_BITS  = cma_pkg::COUNT_BITS_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input cma_pkg::t_out_item i_out_data
);
    import cma_pkg::*;

    localparam logic [CLASS_W-1:0] COL_LAST = CLASS_W'(CLASS_COUNT - 1);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("result changed while stalled");

    a_row_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_data.last) |-> !i_in_ready)
        else $error("input taken in the middle of a row read");

    a_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.last) |-> (i_out_data.column == COL_LAST))
        else $error("last flag on a column other than the final one");

    if (COUNT_BITS <= COUNT_OUT_W) begin : g_full_width
        a_cnt_le_tot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            i_out_valid |-> (i_out_data.cell_count <= i_out_data.row_total))
            else $error("cell count above its row total");

        a_full_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (i_out_valid && i_out_data.row_total != '0
             && i_out_data.cell_count == i_out_data.row_total)
            |-> (i_out_data.fraction == '1))
            else $error("full row does not read full scale");
    end
endmodule

bind confusion_matrix_accumulator cma_chk #(
    .CLASS_COUNT (CLASS_COUNT),
    .COUNT_BITS  (COUNT_BITS)
) u_cma_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for confusion_matrix_accumulator
// Directed table, then weighted random record/read/clear traffic with random
// source and sink idling. Row read-outs are checked field by field against a
// matrix predictor kept in the bench, or against the table for typed rows.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import cma_pkg::*;

    localparam int CLASSES      = CLASS_COUNT_DEF;
    localparam int RANDOM_ITEMS = 448;
    localparam int DRAIN_CYCLES = 400;
    localparam int CYCLE_LIMIT  = 2_000_000;

    typedef struct packed {
        logic [OPCODE_W-1:0]    op;
        logic [CLASS_W-1:0]     tc;
        logic [CLASS_W-1:0]     pc;
        logic                   typed;
        logic [CLASS_W-1:0]     hot_col;
        logic [COUNT_OUT_W-1:0] hot_cnt;
        logic [COUNT_OUT_W-1:0] total;
        logic [FRAC_W-1:0]      hot_frac;
    } t_stim_row;

    // typed rows: every column but hot_col reads count 0, fraction 0
    localparam int DIRECTED_ROWS = 22;
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        '{OP_READ,   4'd0,  4'd0,  1'b1, 4'd0,  32'd0, 32'd0, 16'd0},
        '{OP_READ,   4'd15, 4'd0,  1'b1, 4'd0,  32'd0, 32'd0, 16'd0},
        '{OP_NOP,    4'd15, 4'd15, 1'b0, 4'd0,  32'd0, 32'd0, 16'd0},
        '{OP_RECORD, 4'd3,  4'd7,  1'b0, 4'd0,  32'd0, 32'd0, 16'd0},
        '{OP_RECORD, 4'd3,  4'd7,  1'b0, 4'd0,  32'd0, 32'd0, 16'd0},
        '{OP_READ,   4'd3,  4'd0,  1'b1, 4'd7,  32'd2, 32'd2, 16'hFFFF},
        '{OP_RECORD, 4'd0,  4'd0,  1'b0, 4'd0,  32'd0, 32'd0, 16'd0},
        '{OP_RECORD, 4'd15, 4'd15, 1'b0, 4'd0,  32'd0, 32'd0, 16'd0},
        '{OP_READ,   4'd15, 4'd0,  1'b1, 4'd15, 32'd1, 32'd1, 16'hFFFF},
        '{OP_READ,   4'd0,  4'd15, 1'b1, 4'd0,  32'd1, 32'd1, 16'hFFFF},
        '{OP_RECORD, 4'd5,  4'd2,  1'b0, 4'd0,  32'd0, 32'd0, 16'd0},
        '{OP_RECORD, 4'd5,  4'd9,  1'b0, 4'd0,  32'd0, 32'd0, 16'd0},
        '{OP_READ,   4'd5,  4'd0,  1'b0, 4'd0,  32'd0, 32'd0, 16'd0},
        '{OP_RECORD, 4'd5,  4'd9,  1'b0, 4'd0,  32'd0, 32'd0, 16'd0},
        '{OP_READ,   4'd5,  4'd0,  1'b0, 4'd0,  32'd0, 32'd0, 16'd0},
        '{OP_NOP,    4'd5,  4'd9,  1'b0, 4'd0,  32'd0, 32'd0, 16'd0},
        '{OP_READ,   4'd5,  4'd0,  1'b0, 4'd0,  32'd0, 32'd0, 16'd0},
        '{OP_CLEAR,  4'd0,  4'd0,  1'b0, 4'd0,  32'd0, 32'd0, 16'd0},
        '{OP_READ,   4'd3,  4'd0,  1'b1, 4'd0,  32'd0, 32'd0, 16'd0},
        '{OP_READ,   4'd5,  4'd0,  1'b1, 4'd0,  32'd0, 32'd0, 16'd0},
        '{OP_RECORD, 4'd10, 4'd15, 1'b0, 4'd0,  32'd0, 32'd0, 16'd0},
        '{OP_READ,   4'd10, 4'd0,  1'b1, 4'd15, 32'd1, 32'd1, 16'hFFFF}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cma_stream_if #(.T(t_in_item))  in_if ();
    cma_stream_if #(.T(t_out_item)) out_if ();

    confusion_matrix_accumulator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    logic [COUNT_OUT_W-1:0] tally_cells  [CLASSES][CLASSES];
    logic [COUNT_OUT_W-1:0] tally_totals [CLASSES];
    t_out_item              row_results_q [$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  n_records = 0, n_reads = 0, n_clears = 0, n_nops = 0;
    int  n_results = 0, n_full_frac = 0, n_empty_row = 0;
    bit  src_burst = 1'b0;
    bit  snk_burst = 1'b0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, row_results_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [FRAC_W-1:0] ratio_q16(logic [COUNT_OUT_W-1:0] cnt,
                                                     logic [COUNT_OUT_W-1:0] tot);
        logic [COUNT_OUT_W+FRAC_W-1:0] scaled;
        if (tot == '0) return '0;
        if (cnt >= tot) return '1;
        scaled = {cnt, {FRAC_W{1'b0}}};
        return FRAC_W'(scaled / tot);
    endfunction

    function automatic void queue_result(t_out_item e);
        if (e.fraction == '1) n_full_frac++;
        if (e.row_total == '0) n_empty_row++;
        row_results_q.push_back(e);
    endfunction

    function automatic void predict_row_read(logic [CLASS_W-1:0] row);
        t_out_item e;
        for (int j = 0; j < CLASSES; j++) begin
            e.column     = CLASS_W'(j);
            e.cell_count = tally_cells[row][j];
            e.row_total  = tally_totals[row];
            e.fraction   = ratio_q16(tally_cells[row][j], tally_totals[row]);
            e.last       = (j == CLASSES - 1);
            queue_result(e);
        end
    endfunction

    function automatic void queue_typed_row(t_stim_row r);
        t_out_item e;
        for (int j = 0; j < CLASSES; j++) begin
            e.column     = CLASS_W'(j);
            e.cell_count = (j == r.hot_col) ? r.hot_cnt : '0;
            e.row_total  = r.total;
            e.fraction   = (j == r.hot_col) ? r.hot_frac : '0;
            e.last       = (j == CLASSES - 1);
            queue_result(e);
        end
    endfunction

    function automatic void clear_matrix();
        for (int i = 0; i < CLASSES; i++) begin
            tally_totals[i] = '0;
            for (int j = 0; j < CLASSES; j++) tally_cells[i][j] = '0;
        end
    endfunction

    // state update for one accepted item; reads queue their row unless typed
    function automatic void matrix_accept(t_in_item it, bit predict_reads);
        case (it.opcode)
            OP_RECORD: begin
                n_records++;
                if (it.true_class < CLASSES && it.predicted_class < CLASSES) begin
                    if (tally_cells[it.true_class][it.predicted_class] != '1)
                        tally_cells[it.true_class][it.predicted_class]++;
                    if (tally_totals[it.true_class] != '1)
                        tally_totals[it.true_class]++;
                end
            end
            OP_READ: begin
                n_reads++;
                if (predict_reads && it.true_class < CLASSES)
                    predict_row_read(it.true_class);
            end
            OP_CLEAR: begin
                n_clears++;
                clear_matrix();
            end
            default: n_nops++;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 100) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        n_results++;
        if (row_results_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result, column %0d", got.column));
            return;
        end
        want = row_results_q.pop_front();
        if (got.column !== want.column)
            report_mismatch($sformatf("column got %0d want %0d", got.column, want.column));
        if (got.cell_count !== want.cell_count)
            report_mismatch($sformatf("col %0d cell_count got %0d want %0d",
                                      want.column, got.cell_count, want.cell_count));
        if (got.row_total !== want.row_total)
            report_mismatch($sformatf("col %0d row_total got %0d want %0d",
                                      want.column, got.row_total, want.row_total));
        if (got.fraction !== want.fraction)
            report_mismatch($sformatf("col %0d fraction got %0d want %0d",
                                      want.column, got.fraction, want.fraction));
        if (got.last !== want.last)
            report_mismatch($sformatf("col %0d last got %0b want %0b",
                                      want.column, got.last, want.last));
    endtask

    // called at a rising edge; returns at the edge of the transfer
    task automatic send_item(input t_in_item it, input int gap, input bit predict_reads);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        matrix_accept(it, predict_reads);
    endtask

    function automatic int source_gap();
        if ($urandom_range(0, 29) == 0) src_burst = !src_burst;
        return src_burst ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic logic [CLASS_W-1:0] pick_row(logic [CLASS_W-1:0] hot [4], int pct);
        if ($urandom_range(0, 99) < pct) return hot[$urandom_range(0, 3)];
        return CLASS_W'($urandom_range(0, CLASSES - 1));
    endfunction

    // sessions of records into a few busy rows, read back now and then;
    // records aimed at hot[0] are correct predictions, but random-opcode items can record any pair
    task automatic run_random(input int target);
        logic [CLASS_W-1:0] hot [4];
        t_in_item           it;
        int                 counted;
        int                 r;
        counted = 0;
        foreach (hot[k]) hot[k] = CLASS_W'($urandom_range(0, CLASSES - 1));
        while (counted < target) begin
            r = $urandom_range(0, 99);
            it.true_class      = CLASS_W'($urandom_range(0, CLASSES - 1));
            it.predicted_class = CLASS_W'($urandom_range(0, CLASSES - 1));
            if (r < 70) begin
                it.opcode     = OP_RECORD;
                it.true_class = pick_row(hot, 70);
                if (it.true_class == hot[0] || $urandom_range(0, 1))
                    it.predicted_class = it.true_class;
            end else if (r < 86) begin
                it.opcode     = OP_READ;
                it.true_class = pick_row(hot, 75);
            end else if (r < 89) begin
                it.opcode = OP_CLEAR;
                foreach (hot[k]) hot[k] = CLASS_W'($urandom_range(0, CLASSES - 1));
            end else if (r < 94) begin
                it.opcode = OP_NOP;
            end else begin
                it.opcode = OPCODE_W'($urandom_range(0, 3));
                if (it.opcode == OP_CLEAR) it.opcode = OP_RECORD;
            end
            send_item(it, source_gap(), 1'b1);
            counted++;
        end
    endtask

    // sink: random stalls, checks every transfer
    initial begin
        int gap;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 29) == 0) snk_burst = !snk_burst;
            gap = snk_burst ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_if.valid) @(posedge i_clk);
            check_result(out_if.data);
        end
    end

    initial begin
        t_in_item it;
        in_if.valid <= 1'b0;
        in_if.data  <= '0;
        clear_matrix();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            it.opcode          = DIRECTED[i].op;
            it.true_class      = DIRECTED[i].tc;
            it.predicted_class = DIRECTED[i].pc;
            send_item(it, source_gap(), !DIRECTED[i].typed);
            if (DIRECTED[i].typed) queue_typed_row(DIRECTED[i]);
        end

        run_random(RANDOM_ITEMS);
        in_if.valid <= 1'b0;

        while (row_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d records, %0d row reads, %0d clears, %0d idle opcodes",
                 n_records, n_reads, n_clears, n_nops);
        $display("%0d results checked, %0d at full scale, %0d from empty rows",
                 n_results, n_full_frac, n_empty_row);
        if (mismatch_count == 0 && row_results_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
